// File: hdl/lce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lce_pkg;

  localparam int OpW      = 3;
  localparam int ColW     = 6;
  localparam int RowW     = 6;
  localparam int DimW     = 7;
  localparam int TickW    = 20;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;

  localparam logic [DimW-1:0]  GridDimReset   = 7'd64;
  localparam logic [TickW-1:0] StepDelayReset = 20'd0;

  typedef enum logic [OpW-1:0] {
    OP_SET    = 3'd0,
    OP_TOGGLE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_TICK   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_STEP_DELAY  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic            alive_value;
  } item_t;

  typedef struct packed {
    logic cell_alive;
    logic generation_done;
  } result_t;

  typedef struct packed {
    logic load;
    logic clr_row;
    logic tick;
    logic gen_init;
    logic gen_load;
    logic gen_row;
    logic rd;
    logic mod;
  } cmd_t;

  typedef struct packed {
    logic gen_due;
    logic h_zero;
    logic clr_last;
    logic gen_last;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/life_cellular_automaton_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Set, toggle, read and unused codes pass through the read and modify states to their result word.
// A tick without a generation goes straight to read and modify; with one it first sweeps
// the grid memory (not at zero height) one row word per cycle through three rows.
// A clear sweeps every memory row, then reads and modifies, before its result word.
// Reset starts a clearing pass of all MAX_HEIGHT rows with busy high; the result strobe
// lasts one cycle and the receiver cannot stall it.
module life_cellular_automaton_engine #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire lce_pkg::item_t               item_i,
  output logic                              res_valid_o,
  output lce_pkg::result_t                  res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [lce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lce_pkg::CfgDataW-1:0] cfg_wdata_i
);

  lce_pkg::cmd_t    cmd;
  lce_pkg::status_t status;

  lce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .op_i    (item_i.operation),
    .status_i(status),
    .cmd_o   (cmd)
  );

  lce_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

// File: hdl/lce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/lce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lce_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [lce_pkg::OpW-1:0] op_i,
  input  wire lce_pkg::status_t        status_i,
  output lce_pkg::cmd_t                cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_TICK  = 8'b0000_0100,
    S_GINIT = 8'b0000_1000,
    S_GLOAD = 8'b0001_0000,
    S_GROW  = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_MOD   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   init_q, init_d;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (op_i == lce_pkg::OP_CLEAR) begin
            state_d = S_CLR;
          end else if (op_i == lce_pkg::OP_TICK) begin
            state_d = S_TICK;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_CLR: begin
        cmd_o.clr_row = 1'b1;
        if (status_i.clr_last) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_RD;
        end
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d    = status_i.gen_due ? S_GINIT : S_RD;
      end
      S_GINIT: begin
        cmd_o.gen_init = 1'b1;
        state_d        = status_i.h_zero ? S_RD : S_GLOAD;
      end
      S_GLOAD: begin
        cmd_o.gen_load = 1'b1;
        state_d        = S_GROW;
      end
      S_GROW: begin
        cmd_o.gen_row = 1'b1;
        if (status_i.gen_last) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/lce_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lce_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lce_pkg::item_t               item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [lce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lce_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire lce_pkg::cmd_t                cmd_i,
  output lce_pkg::status_t                  status_o,
  output logic                              res_valid_o,
  output lce_pkg::result_t                  res_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WA = ($clog2(MAX_WIDTH + 1) > lce_pkg::DimW) ?
                      $clog2(MAX_WIDTH + 1) : lce_pkg::DimW;
  localparam int HA = (HW > lce_pkg::DimW) ? HW : lce_pkg::DimW;
  localparam logic [3:0] LiveKeep  = 4'd2;
  localparam logic [3:0] LiveBirth = 4'd3;

  function automatic logic life_rule(input logic self, input logic [7:0] nb);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nb[i]);
    end
    return (n == LiveBirth) || (self && (n == LiveKeep));
  endfunction

  logic [lce_pkg::DimW-1:0]  grid_width_q, grid_height_q;
  logic [lce_pkg::TickW-1:0] step_delay_q, tick_cnt_q, tick_inc;
  lce_pkg::item_t            item_q;
  logic                      gen_flag_q;
  logic [HW-1:0]             row_cnt_q;
  logic [MAX_WIDTH-1:0]      above_q, cur_q;
  logic                      res_valid_q;
  lce_pkg::result_t          res_q;

  logic [WA-1:0]        grid_w_ext, act_w;
  logic [HA-1:0]        grid_h_ext, act_h, rp1;
  logic [MAX_WIDTH-1:0] col_mask;
  logic                 in_area, below_ok;

  logic                 ram_we;
  logic [YW-1:0]        ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0] ram_wdata, rd_data;

  logic [MAX_WIDTH-1:0] mid_m, below_m, gen_word;
  logic [MAX_WIDTH-1:0] a_l, a_r, m_l, m_r, b_l, b_r;

  logic [XW-1:0]        xi;
  logic                 op_set, op_toggle, cell_old, new_bit, wr_cell, cell_now;
  logic [MAX_WIDTH-1:0] cell_oh, cell_word;

  assign grid_w_ext = WA'(grid_width_q);
  assign grid_h_ext = HA'(grid_height_q);
  assign act_w = (grid_w_ext > WA'(MAX_WIDTH))  ? WA'(MAX_WIDTH)  : grid_w_ext;
  assign act_h = (grid_h_ext > HA'(MAX_HEIGHT)) ? HA'(MAX_HEIGHT) : grid_h_ext;

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
    assign col_mask[c] = (WA'(c) < act_w);
  end

  assign in_area = (WA'(item_q.column) < act_w) && (HA'(item_q.row) < act_h);

  assign tick_inc = (&tick_cnt_q) ? tick_cnt_q : tick_cnt_q + lce_pkg::TickW'(1);
  assign rp1      = HA'(row_cnt_q) + HA'(1);
  assign below_ok = (rp1 < act_h);

  assign status_o.gen_due  = (tick_inc >= step_delay_q);
  assign status_o.h_zero   = (act_h == '0);
  assign status_o.clr_last = (row_cnt_q == HW'(MAX_HEIGHT - 1));
  assign status_o.gen_last = !below_ok;

  assign mid_m   = cur_q & col_mask;
  assign below_m = below_ok ? (rd_data & col_mask) : '0;
  assign a_l = above_q << 1;
  assign a_r = above_q >> 1;
  assign m_l = mid_m << 1;
  assign m_r = mid_m >> 1;
  assign b_l = below_m << 1;
  assign b_r = below_m >> 1;

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      gen_word[c] = life_rule(mid_m[c], {a_l[c], above_q[c], a_r[c], m_l[c], m_r[c],
                                         b_l[c], below_m[c], b_r[c]});
    end
  end

  assign xi        = XW'(item_q.column);
  assign op_set    = (item_q.operation == lce_pkg::OP_SET);
  assign op_toggle = (item_q.operation == lce_pkg::OP_TOGGLE);
  assign cell_old  = rd_data[xi];
  assign new_bit   = op_set ? item_q.alive_value : ~cell_old;
  assign wr_cell   = (op_set || op_toggle) && in_area;
  assign cell_oh   = {{(MAX_WIDTH - 1){1'b0}}, 1'b1} << xi;
  assign cell_word = new_bit ? (rd_data | cell_oh) : (rd_data & ~cell_oh);
  assign cell_now  = wr_cell ? new_bit : cell_old;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = YW'(row_cnt_q);
    ram_wdata = '0;
    ram_raddr = '0;
    if (cmd_i.clr_row) begin
      ram_we = 1'b1;
    end
    if (cmd_i.gen_init) begin
      ram_raddr = '0;
    end
    if (cmd_i.gen_load) begin
      ram_raddr = YW'(1);
    end
    if (cmd_i.gen_row) begin
      ram_raddr = YW'(row_cnt_q + HW'(2));
      ram_we    = 1'b1;
      ram_wdata = (gen_word & col_mask) | (cur_q & ~col_mask);
    end
    if (cmd_i.rd) begin
      ram_raddr = YW'(item_q.row);
    end
    if (cmd_i.mod) begin
      ram_we    = wr_cell;
      ram_waddr = YW'(item_q.row);
      ram_wdata = cell_word;
    end
  end

  lce_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= lce_pkg::GridDimReset;
      grid_height_q <= lce_pkg::GridDimReset;
      step_delay_q  <= lce_pkg::StepDelayReset;
      tick_cnt_q    <= '0;
      gen_flag_q    <= 1'b0;
      row_cnt_q     <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lce_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[lce_pkg::DimW-1:0];
          lce_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[lce_pkg::DimW-1:0];
          lce_pkg::CFG_STEP_DELAY:  step_delay_q  <= cfg_wdata_i[lce_pkg::TickW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load) begin
        gen_flag_q <= 1'b0;
        row_cnt_q  <= '0;
      end
      if (cmd_i.clr_row || cmd_i.gen_row) begin
        row_cnt_q <= row_cnt_q + HW'(1);
      end
      if (cmd_i.tick) begin
        tick_cnt_q <= status_o.gen_due ? '0 : tick_inc;
        gen_flag_q <= status_o.gen_due;
      end
      if (cmd_i.gen_init) begin
        row_cnt_q <= '0;
      end
      res_valid_q <= cmd_i.mod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.gen_init) begin
      above_q <= '0;
    end
    if (cmd_i.gen_load) begin
      cur_q <= rd_data;
    end
    if (cmd_i.gen_row) begin
      above_q <= mid_m;
      cur_q   <= rd_data;
    end
    if (cmd_i.mod) begin
      res_q.cell_alive      <= cell_now && in_area;
      res_q.generation_done <= gen_flag_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: hdl/lce_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lce_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic res_valid_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> busy && !res_valid_o)
    else $error("Engine must be busy and silent during reset.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("An accepted word must make the engine busy.");

  a_strobe_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy && $past(busy))
    else $error("A result word must appear just as the engine goes idle.");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("A result strobe must last a single cycle.");

endmodule

bind life_cellular_automaton_engine lce_checker u_lce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o)
);
`default_nettype wire
